FILE: hw/rtl/skip_list_priority_queue_defines.svh
// Assertion macros for the skip-list priority queue.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef SKIP_LIST_PRIORITY_QUEUE_DEFINES_SVH
`define SKIP_LIST_PRIORITY_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SLPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SLPQ_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SLPQ_ASSERT(label, clk, rst, prop)
`define SLPQ_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: hw/rtl/slpq_pkg.sv
// Package for the skip-list priority queue: field widths, defaults, states.
// No dependencies.
package slpq_pkg;
   localparam int DefNodes  = 64;
   localparam int DefLevels = 16;
   localparam int HandleW   = 6;
   localparam int KeyW      = 64;
   localparam int LevelW    = 4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_SRCH_RD,
      ST_SRCH_KEY,
      ST_SRCH_CMP,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_TOP_RD,
      ST_TOP_CHK,
      ST_FIRST_RD,
      ST_FIRST_KEY,
      ST_RESP
   } state_type;
endpackage

FILE: hw/rtl/slpq_if.sv
// Valid/ready channel interface for the skip-list priority queue.
// Depends on nothing; payload width parameters set by the user.
interface slpq_req_if #(parameter int HW = 6, parameter int KW = 64, parameter int LW = 4);
   logic          valid;
   logic          ready;
   logic          func;
   logic [HW-1:0] handle;
   logic [KW-1:0] key;
   logic [LW-1:0] level;
   modport source (output valid, func, handle, key, level, input ready);
   modport sink   (input valid, func, handle, key, level, output ready);
endinterface

interface slpq_rsp_if #(parameter int HW = 6, parameter int KW = 64, parameter int LW = 4);
   logic          valid;
   logic          ready;
   logic          error;
   logic          empty_res;
   logic [HW-1:0] first_handle;
   logic [KW-1:0] first_key;
   logic [LW-1:0] top_level;
   modport source (output valid, error, empty_res, first_handle, first_key, top_level,
                   input ready);
   modport sink   (input valid, error, empty_res, first_handle, first_key, top_level,
                   output ready);
endinterface

FILE: hw/rtl/skip_list_priority_queue.sv
// Skip-list priority queue: top level with sequencer, link and key memories.
// Depends on slpq_pkg, slpq_if and skip_list_priority_queue_defines.svh.
//
// Usage: one request on req_ (func, handle, key, level) gives one response
// on rsp_ (error, first handle/key, empty flag, top level). Insert of a
// linked handle or delete of an unlinked one is flagged and ignored.
// Node links live in one memory read and written at one address a cycle;
// keys in a second memory. A request is taken only while the sequencer is
// idle, one at a time. After reset a clearing pass over all (NODES+1)*LEVELS
// link words points each of them at the head sentinel; no request is taken
// meanwhile. The response waits in a register until taken; meanwhile one
// more request is taken and worked, and its result holds the sequencer
// until the register frees.
`include "skip_list_priority_queue_defines.svh"
module skip_list_priority_queue
   import slpq_pkg::*;
#(
   parameter int NODES  = DefNodes,
   parameter int LEVELS = DefLevels
) (
   input logic clock,
   input logic reset,
   slpq_req_if.sink   req,
   slpq_rsp_if.source rsp
);
   localparam int NW  = $clog2(NODES + 1);
   localparam int LV  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int AW  = NW + LV;
   localparam int DEP = (NODES + 1) * LEVELS;
   localparam int HIW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [NW-1:0] HEAD = NW'(NODES);
   localparam logic [LV-1:0] LMAX = LV'(LEVELS - 1);

   // link word: forward in the upper half, backward in the lower
   logic [2*NW-1:0] link_mem [DEP];
   logic [KeyW-1:0] key_mem [NODES];
   logic [LV-1:0]   lvl_mem [NODES];
   logic [NODES-1:0] linked_ff, linked_in;

   state_type state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            func_ff;
   logic [NW-1:0]   h_ff;
   logic [KeyW-1:0] key_ff;
   logic [LV-1:0]   want_ff, want_in;
   logic [LV-1:0]   top_ff, top_in;
   logic [LV-1:0]   lv_ff, lv_in;
   logic [NW-1:0]   p_ff, p_in;
   logic [NW-1:0]   q_ff, q_in;
   logic [NW-1:0]   upd_ff [LEVELS];
   logic [NW-1:0]   nb_ff, nb_in;
   logic [1:0]      ph_ff, ph_in;
   logic            err_ff, err_in;
   logic            rvalid_ff;
   logic [NW-1:0]   first_ff, first_in;

   logic [AW-1:0]   rd_addr, wr_addr;
   logic            wr_en;
   logic [2*NW-1:0] wr_data, rd_ff;
   logic [NW-1:0]   rd_fwd, rd_bwd;
   logic [HIW-1:0]  kaddr;
   logic [KeyW-1:0] kd_ff;
   logic [LV-1:0]   ld_ff;
   logic            rsp_take;
   logic            rsp_load;

   function automatic logic [AW-1:0] la(input logic [NW-1:0] n, input logic [LV-1:0] l);
      la = AW'(n) * AW'(LEVELS) + AW'(l);
   endfunction

   assign rd_fwd   = rd_ff[2*NW-1:NW];
   assign rd_bwd   = rd_ff[NW-1:0];
   assign rsp_take = rvalid_ff && rsp.ready;
   assign rsp_load = (state_ff == ST_RESP) && (!rvalid_ff || rsp_take);
   assign req.ready = (state_ff == ST_IDLE);

   // memories: one read, one write a cycle, registered read
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_data;
      rd_ff <= link_mem[rd_addr];
      if (state_ff == ST_CHECK && func_ff == FUNC_INSERT && !linked_ff[h_ff[HIW-1:0]]) begin
         key_mem[h_ff[HIW-1:0]] <= key_ff;
      end
      if (state_ff == ST_INS_RD && ph_ff == 2'd0 && lv_ff == want_ff) begin
         lvl_mem[h_ff[HIW-1:0]] <= want_ff;
      end
      kd_ff <= key_mem[kaddr];
      ld_ff <= lvl_mem[kaddr];
   end

   // payload of the accepted request
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         func_ff <= req.func;
         h_ff    <= NW'(req.handle);
         key_ff  <= req.key;
      end
   end

   // search path record
   always_ff @(posedge clock) begin
      if (state_ff == ST_SRCH_CMP && (q_ff >= HEAD || kd_ff > key_ff || nb_ff == NW'(NODES)))
         upd_ff[lv_ff] <= p_ff;
      if (state_ff == ST_SRCH_RD && ph_ff == 2'd0 && lv_ff > top_ff) upd_ff[lv_ff] <= HEAD;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         linked_ff <= '0;
         top_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         linked_ff <= linked_in;
         top_ff    <= top_in;
         if (rsp_load) rvalid_ff <= 1'b1;
         else if (rsp_take) rvalid_ff <= 1'b0;
      end
      want_ff  <= want_in;
      lv_ff    <= lv_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      nb_ff    <= nb_in;
      ph_ff    <= ph_in;
      err_ff   <= err_in;
      first_ff <= first_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req.valid && req.ready) state_in = ST_CHECK;
         ST_CLEAR:     if (clr_ff == AW'(DEP - 1)) state_in = ST_IDLE;
         ST_CHECK: begin
            priority if (h_ff >= HEAD) state_in = ST_FIRST_RD;
            else if (func_ff == FUNC_INSERT && linked_ff[h_ff[HIW-1:0]])
               state_in = ST_FIRST_RD;
            else if (func_ff == FUNC_DELETE && !linked_ff[h_ff[HIW-1:0]])
               state_in = ST_FIRST_RD;
            else if (func_ff == FUNC_INSERT) state_in = ST_SRCH_RD;
            else state_in = ST_DEL_RD;
         end
         ST_SRCH_RD:   state_in = (ph_ff == 2'd0) ? ST_SRCH_RD : ST_SRCH_KEY;
         ST_SRCH_KEY:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (q_ff >= HEAD || kd_ff > key_ff || nb_ff == NW'(NODES)) begin
               state_in = (lv_ff == '0) ? ST_INS_RD : ST_SRCH_RD;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_INS_RD:    state_in = (ph_ff == 2'd1) ? ST_INS_WR : ST_INS_RD;
         ST_INS_WR:    state_in = (ph_ff == 2'd3 && lv_ff == '0) ? ST_FIRST_RD :
                                  ((ph_ff == 2'd3) ? ST_INS_RD : ST_INS_WR);
         ST_DEL_RD:    state_in = (ph_ff == 2'd1) ? ST_DEL_WR : ST_DEL_RD;
         ST_DEL_WR:    state_in = (ph_ff == 2'd3) ?
                                  ((lv_ff == want_ff) ? ST_TOP_RD : ST_DEL_RD) : ST_DEL_WR;
         ST_TOP_RD:    state_in = ST_TOP_CHK;
         ST_TOP_CHK:   state_in = (lv_ff == '0 || rd_fwd != HEAD || rd_bwd != HEAD)
                                  ? ST_FIRST_RD : ST_TOP_RD;
         ST_FIRST_RD:  state_in = (ph_ff == 2'd1) ? ST_FIRST_KEY : ST_FIRST_RD;
         ST_FIRST_KEY: state_in = ST_RESP;
         ST_RESP:      state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in    = clr_ff;
      linked_in = linked_ff;
      top_in    = top_ff;
      want_in   = want_ff;
      lv_in     = lv_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      nb_in     = nb_ff;
      ph_in     = ph_ff;
      err_in    = err_ff;
      first_in  = first_ff;
      rd_addr   = '0;
      wr_addr   = clr_ff;
      wr_en     = 1'b0;
      wr_data   = {HEAD, HEAD};
      kaddr     = q_ff[HIW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            ph_in = 2'd0;
            if (req.valid && req.ready) begin
               want_in = (req.level > LevelW'(LEVELS - 1)) ? LMAX : LV'(req.level);
            end
         end
         ST_CHECK: begin
            err_in = 1'b1;
            kaddr  = h_ff[HIW-1:0];
            ph_in  = 2'd0;
            nb_in  = '0;
            if (h_ff < HEAD) begin
               if (func_ff == FUNC_INSERT && !linked_ff[h_ff[HIW-1:0]]) begin
                  err_in = 1'b0;
                  lv_in  = (want_ff > top_ff) ? top_ff + LV'(1) : top_ff;
                  p_in   = HEAD;
                  if (want_ff > top_ff) begin
                     want_in = top_ff + LV'(1);
                     top_in  = top_ff + LV'(1);
                  end
               end else if (func_ff == FUNC_DELETE && linked_ff[h_ff[HIW-1:0]]) begin
                  err_in = 1'b0;
                  lv_in  = '0;
               end
            end
         end
         ST_SRCH_RD: begin
            rd_addr = la(p_ff, lv_ff);
            ph_in   = (ph_ff == 2'd0) ? 2'd1 : 2'd0;
         end
         ST_SRCH_KEY: begin
            q_in  = rd_fwd;
            kaddr = rd_fwd[HIW-1:0];
         end
         ST_SRCH_CMP: begin
            if (q_ff >= HEAD || kd_ff > key_ff || nb_ff == NW'(NODES)) begin
               nb_in = '0;
               if (lv_ff == '0) begin
                  lv_in = want_ff;
                  ph_in = 2'd0;
               end else begin
                  lv_in = lv_ff - LV'(1);
               end
            end else begin
               p_in  = q_ff;
               nb_in = nb_ff + NW'(1);
            end
         end
         ST_INS_RD: begin
            rd_addr = la(upd_ff[lv_ff], lv_ff);
            ph_in   = (ph_ff == 2'd0) ? 2'd1 : 2'd0;
            if (ph_ff == 2'd1) linked_in[h_ff[HIW-1:0]] = 1'b1;
         end
         ST_INS_WR: begin
            ph_in = ph_ff + 2'd1;
            q_in  = (ph_ff == 2'd0) ? ((rd_fwd > HEAD) ? HEAD : rd_fwd) : q_ff;
            unique case (ph_ff)
               2'd0: begin
                  // new node: fwd=next, bwd=pred; keep the predecessor's bwd
                  p_in    = rd_bwd;
                  wr_en   = 1'b1;
                  wr_addr = la(h_ff, lv_ff);
                  wr_data = {((rd_fwd > HEAD) ? HEAD : rd_fwd), upd_ff[lv_ff]};
                  rd_addr = la((rd_fwd > HEAD) ? HEAD : rd_fwd, lv_ff);
               end
               2'd1: begin
                  wr_en   = 1'b1;
                  wr_addr = la(upd_ff[lv_ff], lv_ff);
                  wr_data = {h_ff, (upd_ff[lv_ff] == q_ff) ? h_ff : p_ff};
                  rd_addr = la(upd_ff[lv_ff], lv_ff);
               end
               2'd2: begin
                  // fetch the next node's word
                  rd_addr = la(q_ff, lv_ff);
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = la(q_ff, lv_ff);
                  wr_data = {(upd_ff[lv_ff] == q_ff) ? h_ff : rd_fwd, h_ff};
                  if (lv_ff != '0) lv_in = lv_ff - LV'(1);
               end
            endcase
         end
         ST_DEL_RD: begin
            kaddr   = h_ff[HIW-1:0];
            rd_addr = la(h_ff, lv_ff);
            ph_in   = (ph_ff == 2'd0) ? 2'd1 : 2'd0;
            if (ph_ff == 2'd1) want_in = ld_ff;
         end
         ST_DEL_WR: begin
            ph_in = ph_ff + 2'd1;
            unique case (ph_ff)
               2'd0: begin
                  p_in    = (rd_bwd > HEAD) ? HEAD : rd_bwd;
                  q_in    = (rd_fwd > HEAD) ? HEAD : rd_fwd;
                  wr_en   = 1'b1;
                  wr_addr = la(h_ff, lv_ff);
                  wr_data = {HEAD, HEAD};
                  rd_addr = la((rd_bwd > HEAD) ? HEAD : rd_bwd, lv_ff);
               end
               2'd1: rd_addr = la(p_ff, lv_ff);
               2'd2: begin
                  wr_en   = 1'b1;
                  wr_addr = la(p_ff, lv_ff);
                  wr_data = {q_ff, (p_ff == q_ff) ? p_ff : rd_bwd};
                  rd_addr = la(q_ff, lv_ff);
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = la(q_ff, lv_ff);
                  wr_data = {(p_ff == q_ff) ? q_ff : rd_fwd, p_ff};
                  if (lv_ff == want_ff) begin
                     linked_in[h_ff[HIW-1:0]] = 1'b0;
                     if (want_ff != top_ff) lv_in = '0;
                  end else begin
                     lv_in = lv_ff + LV'(1);
                  end
               end
            endcase
         end
         ST_TOP_RD: begin
            rd_addr = la(HEAD, lv_ff);
            if (want_ff != top_ff) lv_in = '0;
         end
         ST_TOP_CHK: begin
            if (want_ff == top_ff) begin
               if (lv_ff == '0 || rd_fwd != HEAD || rd_bwd != HEAD) top_in = lv_ff;
               else lv_in = lv_ff - LV'(1);
            end
            ph_in = 2'd0;
         end
         ST_FIRST_RD: begin
            rd_addr = la(HEAD, '0);
            ph_in   = (ph_ff == 2'd0) ? 2'd1 : 2'd0;
         end
         ST_FIRST_KEY: begin
            first_in = rd_fwd;
            kaddr    = rd_fwd[HIW-1:0];
         end
         ST_RESP: begin
            // hold the first key while the response register is busy
            kaddr = first_ff[HIW-1:0];
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp.error        <= err_ff;
         rsp.empty_res    <= first_ff >= HEAD;
         rsp.first_handle <= (first_ff >= HEAD) ? '0 : HandleW'(first_ff);
         rsp.first_key    <= (first_ff >= HEAD) ? '0 : kd_ff;
         rsp.top_level    <= LevelW'(top_ff);
      end
   end
   assign rsp.valid = rvalid_ff;

   `SLPQ_ASSERT(a_no_req_busy, clock, reset, (state_ff != ST_IDLE) |-> !req.ready)
   `SLPQ_ASSERT(a_top_bound, clock, reset, top_ff <= LMAX)
   `SLPQ_ASSERT(a_rsp_after_work, clock, reset, $rose(rvalid_ff) |-> $past(state_ff) == ST_RESP)
   `SLPQ_ASSERT(a_empty_top, clock, reset, (rvalid_ff && rsp.empty_res) |-> rsp.top_level == '0)
   `SLPQ_ASSERT(a_link_upd, clock, reset, (state_ff == ST_CLEAR) |-> !rvalid_ff)
endmodule

FILE: bench/tb.sv
// Self-checking bench for the skip-list priority queue: directed and random
// insert/delete traffic checked against a behavioral skip list kept in the bench.
// Depends on slpq_pkg, slpq_if.sv and the skip_list_priority_queue RTL.
module tb
   import slpq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumNodes  = DefNodes;
   localparam int NumLevels = DefLevels;
   localparam int HeadSlot  = NumNodes;
   localparam int IdleLimit = 8000;

   typedef struct packed {
      logic                err;
      logic                empty;
      logic [HandleW-1:0]  handle;
      logic [KeyW-1:0]     key;
      logic [LevelW-1:0]   top;
   } queue_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slpq_req_if #(.HW(HandleW), .KW(KeyW), .LW(LevelW)) req_ch ();
   slpq_rsp_if #(.HW(HandleW), .KW(KeyW), .LW(LevelW)) rsp_ch ();

   skip_list_priority_queue dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of the list
   int             next_link [(NumNodes+1)*NumLevels];
   int             prev_link [(NumNodes+1)*NumLevels];
   logic [KeyW-1:0] node_key [NumNodes];
   int             node_lvl  [NumNodes];
   bit             in_list   [NumNodes];
   int             list_top;
   int             list_count;

   queue_status_type status_q [$];
   int             fail_count;
   int             send_gap_pct;
   int             stall_pct;
   int             hold_left;
   int             idle_cycles;
   int             n_insert, n_delete, n_reject, max_top;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int lnk(input int n, input int l);
      return n * NumLevels + l;
   endfunction

   // apply one accepted request to the bench list and return the status
   function automatic queue_status_type update_list(input logic fn, input int h,
                                                    input logic [KeyW-1:0] k,
                                                    input int want);
      queue_status_type s;
      int upd [NumLevels];
      int p, q, steps, pp, nn, m, first;
      s = '0;
      if (fn == FUNC_INSERT && in_list[h]) begin
         s.err = 1'b1;
      end else if (fn == FUNC_DELETE && !in_list[h]) begin
         s.err = 1'b1;
      end else if (fn == FUNC_INSERT) begin
         p = HeadSlot;
         for (int lv = list_top; lv >= 0; lv--) begin
            steps = 0;
            while (steps < NumNodes) begin
               q = next_link[lnk(p, lv)];
               if (q >= NumNodes || node_key[q] > k) break;
               p = q;
               steps++;
            end
            upd[lv] = p;
         end
         if (want > NumLevels - 1) want = NumLevels - 1;
         if (want > list_top) begin
            list_top++;
            want = list_top;
            upd[want] = HeadSlot;
         end
         node_key[h] = k;
         node_lvl[h] = want;
         in_list[h] = 1'b1;
         list_count++;
         for (int lv = want; lv >= 0; lv--) begin
            pp = upd[lv];
            nn = next_link[lnk(pp, lv)];
            next_link[lnk(h, lv)] = nn;
            next_link[lnk(pp, lv)] = h;
            prev_link[lnk(h, lv)] = pp;
            prev_link[lnk(nn, lv)] = h;
         end
      end else begin
         m = node_lvl[h];
         for (int lv = 0; lv <= m; lv++) begin
            pp = prev_link[lnk(h, lv)];
            nn = next_link[lnk(h, lv)];
            next_link[lnk(pp, lv)] = nn;
            prev_link[lnk(nn, lv)] = pp;
            next_link[lnk(h, lv)] = HeadSlot;
            prev_link[lnk(h, lv)] = HeadSlot;
         end
         if (m == list_top) begin
            while (m > 0 && next_link[lnk(HeadSlot, m)] == HeadSlot &&
                   prev_link[lnk(HeadSlot, m)] == HeadSlot)
               m--;
            list_top = m;
         end
         in_list[h] = 1'b0;
         list_count--;
      end
      first = next_link[lnk(HeadSlot, 0)];
      if (first >= NumNodes) begin
         s.empty = 1'b1;
      end else begin
         s.handle = first[HandleW-1:0];
         s.key = node_key[first];
      end
      s.top = list_top[LevelW-1:0];
      return s;
   endfunction

   // offer one request, hold it until taken, then record the expected status
   task automatic send_request(input logic fn, input int h, input logic [KeyW-1:0] k,
                               input int lvl);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.func   <= fn;
      req_ch.handle <= h[HandleW-1:0];
      req_ch.key    <= k;
      req_ch.level  <= lvl[LevelW-1:0];
      do @(posedge clock); while (!req_ch.ready);
      status_q.push_back(update_list(fn, h, k, lvl));
      if (fn == FUNC_INSERT) n_insert++; else n_delete++;
      if (list_top > max_top) max_top = list_top;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (status_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [KeyW-1:0] pick_key();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2, 3: return KeyW'($urandom_range(7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int pick_level();
      int l;
      l = 0;
      if ($urandom_range(4) == 0) return $urandom_range(15);
      while (l < 15 && $urandom_range(1)) l++;
      return l;
   endfunction

   function automatic int pick_handle(input bit want_linked);
      int h;
      h = $urandom_range(NumNodes - 1);
      for (int i = 0; i < NumNodes; i++)
         if (in_list[(h + i) % NumNodes] == want_linked) return (h + i) % NumNodes;
      return h;
   endfunction

   // edge keys, level capping, equal keys and both kinds of rejection
   task automatic test_directed();
      send_request(FUNC_DELETE, 5, '0, 0);
      send_request(FUNC_INSERT, 0, '0, 0);
      send_request(FUNC_INSERT, 0, '1, 3);
      send_request(FUNC_INSERT, 63, '1, 15);
      send_request(FUNC_INSERT, 10, 64'h5, 15);
      send_request(FUNC_INSERT, 11, 64'h5, 2);
      send_request(FUNC_INSERT, 12, 64'h5, 15);
      send_request(FUNC_INSERT, 13, 64'haaaa_aaaa_aaaa_aaaa, 10);
      send_request(FUNC_INSERT, 42, 64'h5555_5555_5555_5555, 5);
      send_request(FUNC_INSERT, 21, '1, 1);
      send_request(FUNC_DELETE, 0, '1, 15);
      send_request(FUNC_DELETE, 0, '0, 0);
      send_request(FUNC_DELETE, 12, '0, 0);
      send_request(FUNC_DELETE, 10, '0, 0);
      send_request(FUNC_DELETE, 11, '0, 0);
      send_request(FUNC_DELETE, 63, '0, 0);
      send_request(FUNC_DELETE, 13, '0, 0);
      send_request(FUNC_DELETE, 42, '0, 0);
      send_request(FUNC_DELETE, 21, '0, 0);
      drain_responses();
   endtask

   // mostly legal traffic that keeps the list populated, some rejected requests
   task automatic test_random_mix(input int n, input int gap, input int stall);
      int r;
      send_gap_pct = gap;
      stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 8)
            send_request(FUNC_INSERT, pick_handle(1'b1), pick_key(), pick_level());
         else if (r < 14)
            send_request(FUNC_DELETE, pick_handle(1'b0), pick_key(), pick_level());
         else if (list_count < 8 || (list_count < NumNodes && r < 58))
            send_request(FUNC_INSERT, pick_handle(1'b0), pick_key(), pick_level());
         else
            send_request(FUNC_DELETE, pick_handle(1'b1), pick_key(), pick_level());
      end
      drain_responses();
   endtask

   // hold the response side off while requests keep coming
   task automatic test_backpressure();
      send_gap_pct = 0;
      stall_pct = 0;
      hold_left = 400;
      for (int i = 0; i < 12; i++)
         send_request(list_count < NumNodes ? FUNC_INSERT : FUNC_DELETE,
                      pick_handle(list_count < NumNodes ? 1'b0 : 1'b1),
                      pick_key(), pick_level());
      drain_responses();
   endtask

   // drive the response ready with random stalls or a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // check each response against the oldest expected status; watch for hangs
   always @(posedge clock) begin
      queue_status_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (status_q.size() == 0) begin
            $display("unexpected response at %0t", $realtime);
            fail_count++;
         end else begin
            e = status_q.pop_front();
            if (rsp_ch.error !== e.err)
               report_mismatch("error", 64'(rsp_ch.error), 64'(e.err));
            if (e.err) n_reject++;
            if (rsp_ch.empty_res !== e.empty)
               report_mismatch("empty_res", 64'(rsp_ch.empty_res), 64'(e.empty));
            if (rsp_ch.first_handle !== e.handle)
               report_mismatch("first_handle", 64'(rsp_ch.first_handle), 64'(e.handle));
            if (rsp_ch.first_key !== e.key)
               report_mismatch("first_key", rsp_ch.first_key, e.key);
            if (rsp_ch.top_level !== e.top)
               report_mismatch("top_level", 64'(rsp_ch.top_level), 64'(e.top));
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("watchdog: no handshake for %0d cycles", IdleLimit);
         $display("FAIL skip_list_priority_queue");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_INSERT;
      req_ch.handle = '0;
      req_ch.key = '0;
      req_ch.level = '0;
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      idle_cycles = 0;
      fail_count = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      n_insert = 0;
      n_delete = 0;
      n_reject = 0;
      max_top = 0;
      list_top = 0;
      list_count = 0;
      for (int i = 0; i < (NumNodes+1)*NumLevels; i++) begin
         next_link[i] = HeadSlot;
         prev_link[i] = HeadSlot;
      end
      for (int i = 0; i < NumNodes; i++) in_list[i] = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(130, 0, 0);
      test_random_mix(130, 63, 0);
      test_backpressure();
      test_random_mix(130, 0, 63);
      test_random_mix(130, 17, 17);

      repeat (200) @(negedge clock);
      if (status_q.size() != 0) begin
         $display("%0d responses never arrived", status_q.size());
         fail_count++;
      end
      $display("covered %0d inserts, %0d deletes, %0d rejected, top level up to %0d",
               n_insert, n_delete, n_reject, max_top);
      $display("idle and stall phases plus one long response hold-off; %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("PASS skip_list_priority_queue");
      else
         $display("FAIL skip_list_priority_queue");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/slpq_pkg.sv
hw/rtl/slpq_if.sv
hw/rtl/skip_list_priority_queue.sv
bench/tb.sv
